### design/gpac_pkg.sv
`timescale 1ns / 1ps

package gpac_pkg;

	localparam int CH_W       = 8;
	localparam int DEN_W      = 16;
	localparam int DIV_STEPS  = CH_W;
	localparam int NUM_W      = DEN_W + DIV_STEPS;
	localparam int CFG_IDX_W  = 2;
	// Four front stages, one stage per quotient bit, one output stage.
	localparam int PIPE_DEPTH = DIV_STEPS + 5;

	typedef enum logic [1:0] {
		OP_FILL   = 2'd0,
		OP_STROKE = 2'd1,
		OP_BLEND  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RED   = 2'd0,
		CFG_GREEN = 2'd1,
		CFG_BLUE  = 2'd2,
		CFG_ALPHA = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_FILL  = 2'd0,
		MODE_BLEND = 2'd1,
		MODE_PASS  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] alpha;
	} pixel_t;

	typedef struct packed {
		mode_t           mode;
		logic [CH_W-1:0] cov;
		pixel_t          dest;
	} side_t;

	// Exact x / 255 for x up to 65152, as ((x + 1) * 257) >> 16.
	function automatic logic [CH_W-1:0] div255(input logic [DEN_W-1:0] x);
		logic [25:0] p;
		p = ({10'd0, x} + 26'd1) * 26'd257;
		return p[23:16];
	endfunction

endpackage

### design/glyph_pixel_alpha_compositor.sv
// Channel   | Handshake                   | Payload
// ----------+-----------------------------+---------------------------------------------
// request   | start, busy (always low)    | operation, coverage, dest_red/green/blue/alpha
// result    | done (one-cycle strobe)     | out_red/green/blue/alpha, write_enable
// config    | cfg_we                      | cfg_index, cfg_data
//
// A request is taken in every cycle that start is high; busy never rises.
// Results leave in the order of their requests, one per cycle.
// The restoring divider resolves one quotient bit per stage over eight stages,
// behind four stages of multiplies.
// Reset clears the valid bits and loads the stroke registers with opaque black.
// The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps

module glyph_pixel_alpha_compositor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [1:0]                     operation,
	input  logic [gpac_pkg::CH_W-1:0]      coverage,
	input  logic [gpac_pkg::CH_W-1:0]      dest_red,
	input  logic [gpac_pkg::CH_W-1:0]      dest_green,
	input  logic [gpac_pkg::CH_W-1:0]      dest_blue,
	input  logic [gpac_pkg::CH_W-1:0]      dest_alpha,
	input  logic                           cfg_we,
	input  logic [gpac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gpac_pkg::CH_W-1:0]      cfg_data,
	output logic                           done,
	output logic [gpac_pkg::CH_W-1:0]      out_red,
	output logic [gpac_pkg::CH_W-1:0]      out_green,
	output logic [gpac_pkg::CH_W-1:0]      out_blue,
	output logic [gpac_pkg::CH_W-1:0]      out_alpha,
	output logic                           write_enable
);
	import gpac_pkg::*;

	localparam int LAST = DIV_STEPS - 1;

	// Stroke color registers, written through the configuration port.
	logic [CH_W-1:0] stroke_red_q, stroke_green_q, stroke_blue_q, stroke_alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stroke_red_q   <= '0;
			stroke_green_q <= '0;
			stroke_blue_q  <= '0;
			stroke_alpha_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_RED:   stroke_red_q   <= cfg_data;
				CFG_GREEN: stroke_green_q <= cfg_data;
				CFG_BLUE:  stroke_blue_q  <= cfg_data;
				CFG_ALPHA: stroke_alpha_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Nothing ever holds the pipeline, so a request is taken whenever it shows up.
	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Stage 1: capture the request and form coverage * stroke alpha + 127.
	logic              valid_s1;
	logic [1:0]        op_s1;
	logic [CH_W-1:0]   cov_s1;
	pixel_t            dest_s1;
	logic [DEN_W-1:0]  prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= operation;
		cov_s1  <= coverage;
		dest_s1 <= '{red: dest_red, green: dest_green, blue: dest_blue, alpha: dest_alpha};
		prod_s1 <= {8'd0, coverage} * {8'd0, stroke_alpha_q} + 16'd127;
	end

	// Stage 2: source alpha and source color, and the decision of what the
	// result will be. A blend whose source alpha is zero, and the unused
	// operation code, both fall back to repeating the destination.
	logic [CH_W-1:0]       sa_c;
	mode_t                 mode_c;
	logic                  valid_s2;
	logic [CH_W-1:0]       sa_s2;
	logic [2:0][CH_W-1:0]  src_s2;
	side_t                 side_s2;

	always_comb begin
		sa_c = (op_s1 == OP_STROKE) ? div255(prod_s1) : cov_s1;
		if (op_s1 == OP_FILL) begin
			mode_c = MODE_FILL;
		end else if ((op_s1 == OP_STROKE || op_s1 == OP_BLEND) && sa_c != '0) begin
			mode_c = MODE_BLEND;
		end else begin
			mode_c = MODE_PASS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		sa_s2   <= sa_c;
		side_s2 <= '{mode: mode_c, cov: cov_s1, dest: dest_s1};
		if (op_s1 == OP_STROKE) begin
			src_s2 <= {stroke_blue_q, stroke_green_q, stroke_red_q};
		end else begin
			src_s2 <= '1;
		end
	end

	// Stage 3: the 8 by 8 products. Channel index 0 is red, 1 green, 2 blue.
	logic                   valid_s3;
	logic [2:0][DEN_W-1:0]  sca_s3;
	logic [DEN_W-1:0]       wda_s3;
	logic [DEN_W-1:0]       sa255_s3;
	side_t                  side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			sca_s3[c] <= {8'd0, src_s2[c]} * {8'd0, sa_s2};
		end
		wda_s3   <= {8'd0, side_s2.dest.alpha} * {8'd0, 8'd255 - sa_s2};
		sa255_s3 <= {sa_s2, 8'd0} - {8'd0, sa_s2};
		side_s3  <= side_s2;
	end

	// Stage 4: numerators and the common divisor of the over operator.
	logic [2:0][CH_W-1:0]   dc_s3;
	logic                   valid_s4;
	logic [2:0][NUM_W-1:0]  num_s4;
	logic [DEN_W-1:0]       den_s4;
	side_t                  side_s4;

	assign dc_s3 = {side_s3.dest.blue, side_s3.dest.green, side_s3.dest.red};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			num_s4[c] <= ({sca_s3[c], 8'd0} - {8'd0, sca_s3[c]})
				+ {16'd0, dc_s3[c]} * {8'd0, wda_s3};
		end
		den_s4  <= sa255_s3 + wda_s3;
		side_s4 <= side_s3;
	end

	// Stages 5 to 12: restoring division, one quotient bit per stage, most
	// significant first. Element k of each array below is stage 5 + k. The
	// numerator is below 256 times the divisor, so eight bits cover the quotient.
	// The result alpha, the divisor over 255, is formed in the first of them.
	logic                              valid_s5 [DIV_STEPS];
	logic [2:0][NUM_W-1:0]             rem_s5   [DIV_STEPS];
	logic [2:0][DIV_STEPS-1:0]         quo_s5   [DIV_STEPS];
	logic [DEN_W-1:0]                  den_s5   [DIV_STEPS];
	logic [CH_W-1:0]                   alpha_s5 [DIV_STEPS];
	side_t                             side_s5  [DIV_STEPS];

	logic                              vin  [DIV_STEPS];
	logic [2:0][NUM_W-1:0]             rin  [DIV_STEPS];
	logic [2:0][DIV_STEPS-1:0]         qin  [DIV_STEPS];
	logic [DEN_W-1:0]                  din  [DIV_STEPS];
	logic [CH_W-1:0]                   ain  [DIV_STEPS];
	side_t                             sin  [DIV_STEPS];
	logic [NUM_W-1:0]                  dsh  [DIV_STEPS];
	logic [2:0]                        take [DIV_STEPS];

	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			if (k == 0) begin
				vin[k] = valid_s4;
				rin[k] = num_s4;
				qin[k] = '0;
				din[k] = den_s4;
				ain[k] = div255(den_s4);
				sin[k] = side_s4;
			end else begin
				vin[k] = valid_s5[k-1];
				rin[k] = rem_s5[k-1];
				qin[k] = quo_s5[k-1];
				din[k] = den_s5[k-1];
				ain[k] = alpha_s5[k-1];
				sin[k] = side_s5[k-1];
			end
			dsh[k] = {8'd0, din[k]} << (DIV_STEPS - 1 - k);
			for (int c = 0; c < 3; c++) begin
				take[k][c] = rin[k][c] >= dsh[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				valid_s5[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				valid_s5[k] <= vin[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			for (int c = 0; c < 3; c++) begin
				rem_s5[k][c] <= take[k][c] ? rin[k][c] - dsh[k] : rin[k][c];
				quo_s5[k][c] <= {qin[k][c][DIV_STEPS-2:0], take[k][c]};
			end
			den_s5[k]   <= din[k];
			alpha_s5[k] <= ain[k];
			side_s5[k]  <= sin[k];
		end
	end

	// Stage 13: pick the result for the mode chosen back in stage 2.
	logic   valid_s13;
	pixel_t out_s13;
	logic   we_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s13 <= 1'b0;
		end else begin
			valid_s13 <= valid_s5[LAST];
		end
	end

	always_ff @(posedge clk) begin
		case (side_s5[LAST].mode)
			MODE_FILL: begin
				out_s13 <= '{red: '1, green: '1, blue: '1, alpha: side_s5[LAST].cov};
				we_s13  <= 1'b1;
			end
			MODE_BLEND: begin
				out_s13 <= '{red: quo_s5[LAST][0], green: quo_s5[LAST][1],
					blue: quo_s5[LAST][2], alpha: alpha_s5[LAST]};
				we_s13  <= 1'b1;
			end
			default: begin
				out_s13 <= side_s5[LAST].dest;
				we_s13  <= 1'b0;
			end
		endcase
	end

	assign done         = valid_s13;
	assign out_red      = out_s13.red;
	assign out_green    = out_s13.green;
	assign out_blue     = out_s13.blue;
	assign out_alpha    = out_s13.alpha;
	assign write_enable = we_s13;

endmodule

### design/gpac_checker.sv
`timescale 1ns / 1ps

module gpac_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic [1:0]                     operation,
	input logic [gpac_pkg::CH_W-1:0]      coverage,
	input logic [gpac_pkg::CH_W-1:0]      dest_red,
	input logic [gpac_pkg::CH_W-1:0]      dest_green,
	input logic [gpac_pkg::CH_W-1:0]      dest_blue,
	input logic [gpac_pkg::CH_W-1:0]      dest_alpha,
	input logic                           done,
	input logic [gpac_pkg::CH_W-1:0]      out_red,
	input logic [gpac_pkg::CH_W-1:0]      out_green,
	input logic [gpac_pkg::CH_W-1:0]      out_blue,
	input logic [gpac_pkg::CH_W-1:0]      out_alpha,
	input logic                           write_enable
);
	import gpac_pkg::*;

	// Track which requests are in flight and which of them are plain fills.
	logic [PIPE_DEPTH-1:0] acc_q, fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			fill_q <= '0;
		end else begin
			acc_q  <= {acc_q[PIPE_DEPTH-2:0], start && !busy};
			fill_q <= {fill_q[PIPE_DEPTH-2:0], start && !busy && operation == OP_FILL};
		end
	end

	a_one_result_per_request: assert property (@(posedge clk) disable iff (!arst_n)
		done == acc_q[PIPE_DEPTH-1])
		else $error("result strobe does not match the request stream");

	a_fill_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && fill_q[PIPE_DEPTH-1] |-> write_enable && out_red == 8'hFF
			&& out_green == 8'hFF && out_blue == 8'hFF
			&& out_alpha == $past(coverage, PIPE_DEPTH))
		else $error("plain fill gave a wrong pixel");

	a_skip_keeps_dest: assert property (@(posedge clk) disable iff (!arst_n)
		done && !write_enable |-> out_red == $past(dest_red, PIPE_DEPTH)
			&& out_green == $past(dest_green, PIPE_DEPTH)
			&& out_blue == $past(dest_blue, PIPE_DEPTH)
			&& out_alpha == $past(dest_alpha, PIPE_DEPTH))
		else $error("skipped pixel does not repeat the destination");

	a_blend_alpha_grows: assert property (@(posedge clk) disable iff (!arst_n)
		done && write_enable && !fill_q[PIPE_DEPTH-1]
			|-> out_alpha >= $past(dest_alpha, PIPE_DEPTH))
		else $error("blend lowered the destination alpha");

endmodule

bind glyph_pixel_alpha_compositor gpac_checker u_gpac_checker (.*);

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

	import gpac_pkg::*;

	// Operation code three carries no meaning; the block must pass the pixel through.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Cycles to wait for the last results before they are declared lost.
	localparam int DRAIN_LIMIT = 200;

	// One predicted result: the pixel that comes out and whether it is written.
	typedef struct packed {
		pixel_t pix;
		logic   wr;
	} pixel_result_t;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 start        = 1'b0;
	logic                 busy;
	logic [1:0]           operation    = OP_FILL;
	logic [CH_W-1:0]      coverage     = '0;
	logic [CH_W-1:0]      dest_red     = '0;
	logic [CH_W-1:0]      dest_green   = '0;
	logic [CH_W-1:0]      dest_blue    = '0;
	logic [CH_W-1:0]      dest_alpha   = '0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = CFG_RED;
	logic [CH_W-1:0]      cfg_data     = '0;
	logic                 done;
	logic [CH_W-1:0]      out_red;
	logic [CH_W-1:0]      out_green;
	logic [CH_W-1:0]      out_blue;
	logic [CH_W-1:0]      out_alpha;
	logic                 write_enable;

	// The bench keeps its own copy of the stroke colour registers, loaded with
	// the reset values of the block: opaque black.
	logic [CH_W-1:0] stroke_red   = 8'd0;
	logic [CH_W-1:0] stroke_green = 8'd0;
	logic [CH_W-1:0] stroke_blue  = 8'd0;
	logic [CH_W-1:0] stroke_alpha = 8'd255;

	// Predicted pixels, oldest first, waiting for the block to produce them.
	pixel_result_t pending_pixels[$];
	pixel_result_t oldest_pixel;

	int mismatches = 0;
	// Chance, in percent, that the sender leaves a cycle empty before a request.
	int idle_pct   = 0;

	glyph_pixel_alpha_compositor dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.coverage     (coverage),
		.dest_red     (dest_red),
		.dest_green   (dest_green),
		.dest_blue    (dest_blue),
		.dest_alpha   (dest_alpha),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.out_alpha    (out_alpha),
		.write_enable (write_enable)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Safety net: a run that hangs, for example on a lost result, ends here.
	initial begin
		#2_000_000;
		$display("glyph_pixel_alpha_compositor test failed");
		$finish;
	end

	// One colour channel of the straight-alpha "over" blend. The numerator fits
	// well inside 32 bits, and the division truncates just like the hardware.
	function automatic logic [CH_W-1:0] blend_channel(int unsigned src, int unsigned dst,
			int unsigned sa, int unsigned da, int unsigned den);
		int unsigned num;
		num = src * sa * 255 + dst * da * (255 - sa);
		return CH_W'(num / den);
	endfunction

	// Predicts the pixel for one request under the current stroke registers.
	function automatic pixel_result_t composite_pixel(logic [1:0] op, logic [CH_W-1:0] cov,
			pixel_t dst);
		pixel_result_t res;
		int unsigned   sa;
		int unsigned   da;
		int unsigned   den;
		pixel_t        src;

		// Anything that does not blend repeats the destination and is not written.
		res.pix = dst;
		res.wr  = 1'b0;
		da      = dst.alpha;

		if (op == OP_FILL) begin
			// A plain fill always writes, even at zero coverage.
			res.pix = '{red: 8'd255, green: 8'd255, blue: 8'd255, alpha: cov};
			res.wr  = 1'b1;
			return res;
		end else if (op == OP_STROKE) begin
			sa  = (int'(cov) * int'(stroke_alpha) + 127) / 255;
			src = '{red: stroke_red, green: stroke_green, blue: stroke_blue, alpha: 8'd0};
		end else if (op == OP_BLEND) begin
			sa  = cov;
			src = '{red: 8'd255, green: 8'd255, blue: 8'd255, alpha: 8'd0};
		end else begin
			return res;
		end

		// A blend whose source alpha came out zero leaves the pixel alone.
		if (sa == 0)
			return res;

		den           = sa * 255 + da * (255 - sa);
		res.pix.red   = blend_channel(src.red, dst.red, sa, da, den);
		res.pix.green = blend_channel(src.green, dst.green, sa, da, den);
		res.pix.blue  = blend_channel(src.blue, dst.blue, sa, da, den);
		res.pix.alpha = CH_W'(den / 255);
		res.wr        = 1'b1;
		return res;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(string name, int got, int want);
		if (got != want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	// Results are sampled at the clock edge that ends their cycle. Each one is
	// matched against the oldest prediction, field by field.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("result with no request waiting for it");
			end else begin
				oldest_pixel = pending_pixels.pop_front();
				compare_field("out_red", out_red, oldest_pixel.pix.red);
				compare_field("out_green", out_green, oldest_pixel.pix.green);
				compare_field("out_blue", out_blue, oldest_pixel.pix.blue);
				compare_field("out_alpha", out_alpha, oldest_pixel.pix.alpha);
				compare_field("write_enable", write_enable, oldest_pixel.wr);
			end
		end
	end

	// Sends one request. It may first leave some cycles empty, then holds start
	// high until the block takes the request. It returns just after the edge
	// that took it, with start still high, so that back-to-back requests keep
	// start high without a glitch.
	task automatic send_request(logic [1:0] op, logic [CH_W-1:0] cov, pixel_t dst);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start      <= 1'b1;
		operation  <= op;
		coverage   <= cov;
		dest_red   <= dst.red;
		dest_green <= dst.green;
		dest_blue  <= dst.blue;
		dest_alpha <= dst.alpha;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_pixels.push_back(composite_pixel(op, cov, dst));
	endtask

	// Stops sending and waits until every predicted result has come back, then
	// lets the pipeline run empty, so that the block is truly idle.
	task automatic drain_pipeline();
		int waited;
		waited = 0;
		start <= 1'b0;
		while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_pixels.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", pending_pixels.size()));
			pending_pixels.delete();
		end
		repeat (PIPE_DEPTH + 2)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CH_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			CFG_RED:   stroke_red   = value;
			CFG_GREEN: stroke_green = value;
			CFG_BLUE:  stroke_blue  = value;
			CFG_ALPHA: stroke_alpha = value;
		endcase
	endtask

	// Loads a new stroke colour. The pipeline is drained first, so no request
	// in flight sees a mix of old and new register values.
	task automatic set_stroke(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b,
			logic [CH_W-1:0] a);
		drain_pipeline();
		write_reg(CFG_RED, r);
		write_reg(CFG_GREEN, g);
		write_reg(CFG_BLUE, b);
		write_reg(CFG_ALPHA, a);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Register values lean toward the extremes, where rounding is most fragile.
	function automatic logic [CH_W-1:0] random_reg_value();
		case ($urandom_range(5))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd1;
			default: return CH_W'($urandom);
		endcase
	endfunction

	// Coverage is zero, one or full often enough to hit the pass-through and
	// smallest-alpha cases many times.
	function automatic logic [CH_W-1:0] random_coverage();
		case ($urandom_range(9))
			0:       return 8'd0;
			1:       return 8'd255;
			2:       return 8'd1;
			default: return CH_W'($urandom);
		endcase
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t p;
		p = pixel_t'($urandom);
		case ($urandom_range(7))
			0: p.alpha = 8'd0;
			1: p.alpha = 8'd255;
			default: ;
		endcase
		return p;
	endfunction

	// The reset stroke colour is opaque black. These requests cover the edges of
	// every operation: zero and full coverage, transparent and opaque
	// destinations, and the unused operation code.
	task automatic test_reset_defaults();
		idle_pct = 36;
		send_request(OP_FILL, 8'd0, random_pixel());
		send_request(OP_FILL, 8'd255, '{8'd0, 8'd0, 8'd0, 8'd0});
		send_request(OP_STROKE, 8'd0, '{8'd12, 8'd34, 8'd56, 8'd78});
		send_request(OP_STROKE, 8'd255, '{8'd255, 8'd255, 8'd255, 8'd255});
		send_request(OP_STROKE, 8'd1, '{8'd200, 8'd100, 8'd50, 8'd0});
		send_request(OP_BLEND, 8'd0, '{8'd1, 8'd2, 8'd3, 8'd4});
		send_request(OP_BLEND, 8'd1, '{8'd255, 8'd255, 8'd255, 8'd255});
		send_request(OP_BLEND, 8'd255, '{8'd0, 8'd0, 8'd0, 8'd0});
		send_request(OP_BLEND, 8'd128, '{8'd90, 8'd160, 8'd30, 8'd0});
		send_request(OP_BLEND, 8'd254, '{8'd0, 8'd0, 8'd0, 8'd255});
		send_request(OP_UNUSED, 8'd255, '{8'd9, 8'd8, 8'd7, 8'd6});
		send_request(OP_UNUSED, 8'd0, '{8'd255, 8'd255, 8'd255, 8'd255});
		drain_pipeline();
	endtask

	// Stroke colour at its extremes: opaque white, fully transparent, and an
	// alpha of one, where coverage rounds to zero below the halfway point.
	task automatic test_stroke_extremes();
		idle_pct = 0;
		set_stroke(8'd255, 8'd255, 8'd255, 8'd255);
		send_request(OP_STROKE, 8'd255, '{8'd0, 8'd0, 8'd0, 8'd0});
		send_request(OP_STROKE, 8'd128, '{8'd0, 8'd0, 8'd0, 8'd255});
		send_request(OP_STROKE, 8'd1, '{8'd255, 8'd0, 8'd255, 8'd128});
		set_stroke(8'd0, 8'd0, 8'd0, 8'd0);
		send_request(OP_STROKE, 8'd255, '{8'd40, 8'd50, 8'd60, 8'd70});
		send_request(OP_STROKE, 8'd0, '{8'd40, 8'd50, 8'd60, 8'd70});
		set_stroke(8'd17, 8'd200, 8'd90, 8'd1);
		send_request(OP_STROKE, 8'd127, '{8'd100, 8'd100, 8'd100, 8'd100});
		send_request(OP_STROKE, 8'd128, '{8'd100, 8'd100, 8'd100, 8'd100});
		send_request(OP_STROKE, 8'd255, '{8'd255, 8'd0, 8'd0, 8'd0});
		drain_pipeline();
	endtask

	// Random requests under a random stroke colour. Most requests are one of the
	// three real operations; a few carry the unused code.
	task automatic test_random_traffic(int count, int pct);
		logic [1:0] op;
		set_stroke(random_reg_value(), random_reg_value(), random_reg_value(),
			random_reg_value());
		idle_pct = pct;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(15) == 0)
				op = OP_UNUSED;
			else
				op = 2'($urandom_range(2));
			send_request(op, random_coverage(), random_pixel());
		end
		drain_pipeline();
	endtask

	initial begin
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_stroke_extremes();
		// The sender is busy and then slow in turn; the last pass sends a request
		// in every cycle to keep the whole pipeline full.
		test_random_traffic(180, 36);
		test_random_traffic(180, 87);
		test_random_traffic(190, 0);

		repeat (PIPE_DEPTH + 4)
			@(posedge clk);
		if (mismatches == 0)
			$display("glyph_pixel_alpha_compositor test passed");
		else
			$display("glyph_pixel_alpha_compositor test failed");
		$finish;
	end

endmodule
